[hw/rtl/cholesky_factorization_top_assert.svh]
// Assertion macros for the RTL of the Cholesky factorization block.
`ifndef CHOLESKY_FACTORIZATION_TOP_ASSERT_SVH
`define CHOLESKY_FACTORIZATION_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CHF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CHF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/chf_pkg.sv]
// ----------------------------------------------------------------------------
// chf_pkg
// Shared types, constants and codes of the Cholesky factorization block.
// ----------------------------------------------------------------------------
`default_nettype none

package chf_pkg;

  localparam int MAX_N_DEF     = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int ACC_W         = 64;

  // The root/divide unit retires two bits per cycle.
  localparam int DIV_CYCLES  = ACC_W / 2;
  localparam int SQRT_CYCLES = ACC_W / 4;
  localparam int UCNT_W      = $clog2(DIV_CYCLES);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOT_POS = 2'd1;
  localparam logic [1:0] STATUS_ZERO    = 2'd2;

  localparam logic       REG_MATRIX_SIZE = 1'b0;
  localparam logic [3:0] SIZE_RESET      = 4'd8;

  typedef struct packed {
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] factor_value;
    logic [1:0]               status;
    logic                     last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_ELEM,
    S_MAC_RD,
    S_MAC_MUL,
    S_MAC_ACC,
    S_V_RD,
    S_V_CALC,
    S_CHECK,
    S_UNIT,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_HOLD
  } chf_state_t;

  typedef struct packed {
    logic       src_we;
    logic       fac_we;
    logic       acc_clr;
    logic       mul_en;
    logic       acc_en;
    logic       v_en;
    logic       unit_start;
    logic       unit_sqrt;
    logic       out_load;
    logic       out_zero;
    logic [1:0] out_status;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic v_neg;
    logic piv_zero;
    logic unit_busy;
  } stat_t;

endpackage

`default_nettype wire

[hw/rtl/chf_stream_if.sv]
// ----------------------------------------------------------------------------
// chf_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface chf_stream_if #(
  parameter type payload_t = logic [31:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/chf_root_div.sv]
// ----------------------------------------------------------------------------
// chf_root_div
// Shared iterative unit: floor square root of a 64-bit value, or signed
// 64-by-32 division truncated toward zero, two result bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chf_root_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            sqrt_mode,
  input  wire logic signed [chf_pkg::ACC_W-1:0]  v,
  input  wire logic signed [chf_pkg::DATA_W-1:0] piv,
  output logic                                 busy,
  output logic signed [chf_pkg::DATA_W-1:0]      result
);
  import chf_pkg::*;

  logic              mode;
  logic              neg;
  logic [UCNT_W-1:0] cnt;
  logic [ACC_W-1:0]  work;
  logic [34:0]       rem;
  logic [31:0]       root;
  logic [31:0]       dvs;

  logic [ACC_W-1:0]  work_next;
  logic [34:0]       rem_next;
  logic [31:0]       root_next;

  // Two dependent restoring steps per cycle.
  always_comb begin
    logic [32:0] r33;
    logic [34:0] r35;
    logic [34:0] trial;
    r33       = '0;
    r35       = '0;
    trial     = '0;
    work_next = work;
    rem_next  = rem;
    root_next = root;
    for (int s = 0; s < 2; s++) begin
      if (mode) begin
        r35       = {rem_next[32:0], work_next[ACC_W-1 -: 2]};
        work_next = {work_next[ACC_W-3:0], 2'b00};
        trial     = {1'b0, root_next, 2'b01};
        if (r35 >= trial) begin
          r35       = r35 - trial;
          root_next = {root_next[30:0], 1'b1};
        end else begin
          root_next = {root_next[30:0], 1'b0};
        end
        rem_next = r35;
      end else begin
        r33       = {rem_next[31:0], work_next[ACC_W-1]};
        work_next = {work_next[ACC_W-2:0], 1'b0};
        if (r33 >= {1'b0, dvs}) begin
          r33          = r33 - {1'b0, dvs};
          work_next[0] = 1'b1;
        end
        rem_next = {2'b00, r33};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= sqrt_mode ? UCNT_W'(SQRT_CYCLES - 1) : UCNT_W'(DIV_CYCLES - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode <= sqrt_mode;
      neg  <= !sqrt_mode && v[ACC_W-1];
      work <= (!sqrt_mode && v[ACC_W-1]) ? ACC_W'(-v) : ACC_W'(v);
      rem  <= '0;
      root <= '0;
      dvs  <= 32'(piv);
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
      root <= root_next;
    end
  end

  // Saturation to the signed 32-bit range.
  always_comb begin
    if (mode) begin
      result = root[31] ? 32'sh7FFF_FFFF : $signed(root);
    end else if (neg) begin
      result = (work > ACC_W'(64'h8000_0000)) ? 32'sh8000_0000 : $signed(32'(-work));
    end else begin
      result = (work > ACC_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(work[31:0]);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/chf_datapath.sv]
// ----------------------------------------------------------------------------
// chf_datapath
// Matrix and factor memories, multiply-accumulate, pivot check, root/divide
// unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module chf_datapath #(
  parameter int MAX_N     = chf_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = chf_pkg::FRAC_BITS_DEF,
  parameter int AW        = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire chf_pkg::cmd_t                   cmd,
  input  wire logic [AW-1:0]                   src_waddr,
  input  wire logic [AW-1:0]                   src_raddr,
  input  wire logic [AW-1:0]                   fac_raddr_a,
  input  wire logic [AW-1:0]                   fac_raddr_b,
  input  wire logic [AW-1:0]                   fac_waddr,
  input  wire logic signed [chf_pkg::DATA_W-1:0] in_data,
  output chf_pkg::stat_t                       stat,
  output chf_pkg::out_item_t                   out_item
);
  import chf_pkg::*;

  localparam int DEPTH = MAX_N * MAX_N;

  logic signed [DATA_W-1:0] src_mem [DEPTH];
  logic signed [DATA_W-1:0] fac_mem [DEPTH];
  logic signed [DATA_W-1:0] src_q;
  logic signed [DATA_W-1:0] fa_q;
  logic signed [DATA_W-1:0] fb_q;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  v;
  logic signed [DATA_W-1:0] piv;
  logic signed [ACC_W-1:0]  a_shift;
  logic signed [ACC_W:0]    sum_w;
  logic signed [ACC_W:0]    diff_w;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  v_next;
  logic                     unit_busy;
  logic signed [DATA_W-1:0] unit_result;

  always_ff @(posedge clk) begin
    if (cmd.src_we) begin
      src_mem[src_waddr] <= in_data;
    end
    src_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.fac_we) begin
      fac_mem[fac_waddr] <= unit_result;
    end
    fa_q <= fac_mem[fac_raddr_a];
    fb_q <= fac_mem[fac_raddr_b];
  end

  assign a_shift = $signed({{(ACC_W - DATA_W){src_q[DATA_W-1]}}, src_q}) <<< FRAC_BITS;
  assign sum_w   = {acc[ACC_W-1], acc} + {prod[ACC_W-1], prod};
  assign diff_w  = {a_shift[ACC_W-1], a_shift} - {acc[ACC_W-1], acc};

  always_comb begin
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      acc_next = sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_next = sum_w[ACC_W-1:0];
    end
    if (diff_w[ACC_W] != diff_w[ACC_W-1]) begin
      v_next = diff_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      v_next = diff_w[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= fa_q * fb_q;
    end
    if (cmd.v_en) begin
      v   <= v_next;
      piv <= fb_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc_next;
    end
  end

  chf_root_div u_root_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.unit_start),
    .sqrt_mode (cmd.unit_sqrt),
    .v         (v),
    .piv       (piv),
    .busy      (unit_busy),
    .result    (unit_result)
  );

  assign stat.v_neg     = v[ACC_W-1];
  assign stat.piv_zero  = (piv <= 0);
  assign stat.unit_busy = unit_busy;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.factor_value <= cmd.out_zero ? '0 : fa_q;
      out_item.status       <= cmd.out_status;
      out_item.last_of_run  <= cmd.out_last;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/chf_ctrl.sv]
// ----------------------------------------------------------------------------
// chf_ctrl
// Sequencer: load indexing, the i/j/k factorization loops and result output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cholesky_factorization_top_assert.svh"

module chf_ctrl #(
  parameter int MAX_N = chf_pkg::MAX_N_DEF,
  parameter int AW    = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [3:0]     cfg_size,
  input  wire logic           cfg_wr,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire chf_pkg::stat_t stat,
  output chf_pkg::cmd_t       cmd,
  output logic [AW-1:0]       src_waddr,
  output logic [AW-1:0]       src_raddr,
  output logic [AW-1:0]       fac_raddr_a,
  output logic [AW-1:0]       fac_raddr_b,
  output logic [AW-1:0]       fac_waddr
);
  import chf_pkg::*;

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  chf_state_t    state, state_next;
  logic [IW-1:0] li, lj, ci, cj, ck, oi, oj;
  logic [IW-1:0] n_m1;
  logic          err_run;
  logic          load_last;
  logic          out_last;

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    addr = AW'(r) * AW'(MAX_N) + AW'(c);
  endfunction

  always_comb begin
    if (cfg_size == 4'd0) begin
      n_m1 = '0;
    end else if (cfg_size > 4'(MAX_N)) begin
      n_m1 = IW'(MAX_N - 1);
    end else begin
      n_m1 = IW'(cfg_size - 4'd1);
    end
  end

  assign load_last = (li == n_m1) && (lj == n_m1);
  assign out_last  = (oi == n_m1) && (oj == n_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid && load_last) begin
          state_next = S_ELEM;
        end
      end
      S_ELEM:    state_next = (cj == '0) ? S_V_RD : S_MAC_RD;
      S_MAC_RD:  state_next = S_MAC_MUL;
      S_MAC_MUL: state_next = S_MAC_ACC;
      S_MAC_ACC: state_next = (ck == cj - 1'b1) ? S_V_RD : S_MAC_RD;
      S_V_RD:    state_next = S_V_CALC;
      S_V_CALC:  state_next = S_CHECK;
      S_CHECK: begin
        if ((ci == cj) ? stat.v_neg : stat.piv_zero) begin
          state_next = S_OUT_HOLD;
        end else begin
          state_next = S_UNIT;
        end
      end
      S_UNIT: begin
        if (!stat.unit_busy) begin
          state_next = (cj == ci && ci == n_m1) ? S_OUT_RD : S_ELEM;
        end
      end
      S_OUT_RD: state_next = S_OUT_LD;
      S_OUT_LD: state_next = S_OUT_HOLD;
      S_OUT_HOLD: begin
        if (out_ready) begin
          state_next = (err_run || out_last) ? S_LOAD : S_OUT_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    src_waddr   = addr(li, lj);
    src_raddr   = addr(ci, cj);
    fac_raddr_a = addr(ci, ck);
    fac_raddr_b = addr(cj, ck);
    fac_waddr   = addr(ci, cj);
    unique case (state)
      S_LOAD: begin
        in_ready   = 1'b1;
        cmd.src_we = in_valid;
      end
      S_ELEM:    cmd.acc_clr = 1'b1;
      S_MAC_MUL: cmd.mul_en  = 1'b1;
      S_MAC_ACC: cmd.acc_en  = 1'b1;
      S_V_RD:    fac_raddr_b = addr(cj, cj);
      S_V_CALC:  cmd.v_en    = 1'b1;
      S_CHECK: begin
        if (ci == cj) begin
          if (stat.v_neg) begin
            cmd.out_load   = 1'b1;
            cmd.out_zero   = 1'b1;
            cmd.out_status = STATUS_NOT_POS;
            cmd.out_last   = 1'b1;
          end else begin
            cmd.unit_start = 1'b1;
            cmd.unit_sqrt  = 1'b1;
          end
        end else if (stat.piv_zero) begin
          cmd.out_load   = 1'b1;
          cmd.out_zero   = 1'b1;
          cmd.out_status = STATUS_ZERO;
          cmd.out_last   = 1'b1;
        end else begin
          cmd.unit_start = 1'b1;
        end
      end
      S_UNIT:   cmd.fac_we = !stat.unit_busy;
      S_OUT_RD: fac_raddr_a = addr(oi, oj);
      S_OUT_LD: begin
        cmd.out_load   = 1'b1;
        cmd.out_zero   = (oj > oi);
        cmd.out_status = STATUS_OK;
        cmd.out_last   = out_last;
      end
      S_OUT_HOLD: out_valid = 1'b1;
      default: ;
    endcase
  end

  // Loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      li <= '0; lj <= '0; ci <= '0; cj <= '0; ck <= '0; oi <= '0; oj <= '0;
      err_run <= 1'b0;
    end else begin
      if (cfg_wr) begin
        li <= '0;
        lj <= '0;
      end else if (state == S_LOAD && in_valid) begin
        if (lj == n_m1) begin
          lj <= '0;
          li <= load_last ? '0 : li + 1'b1;
        end else begin
          lj <= lj + 1'b1;
        end
      end
      case (state)
        S_LOAD: begin
          ci      <= '0;
          cj      <= '0;
          err_run <= 1'b0;
        end
        S_ELEM:    ck <= '0;
        S_MAC_ACC: ck <= ck + 1'b1;
        S_CHECK: begin
          err_run <= (ci == cj) ? stat.v_neg : stat.piv_zero;
        end
        S_UNIT: begin
          if (!stat.unit_busy) begin
            if (cj == ci) begin
              cj <= '0;
              ci <= ci + 1'b1;
              oi <= '0;
              oj <= '0;
            end else begin
              cj <= cj + 1'b1;
            end
          end
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            if (oj == n_m1) begin
              oj <= '0;
              oi <= oi + 1'b1;
            end else begin
              oj <= oj + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `CHF_ASSERT_SAME(a_start_idle, cmd.unit_start, !stat.unit_busy)
  `CHF_ASSERT_NEXT(a_start_busy, cmd.unit_start, stat.unit_busy)
  `CHF_ASSERT_SAME(a_no_load_in_out, in_ready, !out_valid)
  `CHF_ASSERT_SAME(a_write_after_unit, cmd.fac_we, state == S_UNIT && !cmd.out_load)

endmodule

`default_nettype wire

[hw/rtl/cholesky_factorization_top.sv]
// ----------------------------------------------------------------------------
// cholesky_factorization_top
// Fixed-point Cholesky factorization of a symmetric matrix of up to MAX_N
// rows, with an APB register for the matrix size.
// ----------------------------------------------------------------------------
// The block takes an n-by-n matrix as n*n input transfers in row-major order
// (signed fixed point with FRAC_BITS fraction bits; entries above the
// diagonal are stored but ignored), then computes the lower-triangular factor
// and returns it as n*n output transfers in row-major order with zeros above
// the diagonal and last_of_run set on the final one. If a diagonal term goes
// negative, a single transfer with status 1 is sent instead; a zero pivot
// that would be divided by gives a single transfer with status 2. Loading
// accepts one element per cycle while in_valid is high. The computation runs
// on one sequencer and one shared root/divide unit: each dot-product term
// passes through read, multiply and saturating accumulate steps, and each
// factor element adds setup and write steps around its square root or
// division. Each result then passes through read, load and hold steps, the
// hold lasting until the sink is ready.
// Input is taken only while loading; the next load starts once the last
// result transfer has completed. The matrix_size register (address 0, reset
// 8; 0 acts as 1 and values above MAX_N act as MAX_N) restarts loading when
// written and must be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cholesky_factorization_top #(
  parameter int MAX_N     = chf_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = chf_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  chf_stream_if.sink       in_ch,
  chf_stream_if.source     out_ch
);
  import chf_pkg::*;

  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;

  logic [3:0]    matrix_size;
  logic          cfg_wr;
  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] src_waddr, src_raddr, fac_raddr_a, fac_raddr_b, fac_waddr;
  in_item_t      in_item;
  out_item_t     out_item;

  // Register decode: one register, selected by word address.
  assign pready = 1'b1;

  always_comb begin
    cfg_wr = 1'b0;
    prdata = '0;
    unique case (paddr[2])
      REG_MATRIX_SIZE: begin
        cfg_wr = psel && penable && pwrite;
        prdata = {28'd0, matrix_size};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_wr) begin
      matrix_size <= pwdata[3:0];
    end
  end

  assign in_item        = in_ch.payload;
  assign out_ch.payload = out_item;

  chf_ctrl #(
    .MAX_N (MAX_N),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_size    (matrix_size),
    .cfg_wr      (cfg_wr),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .stat        (stat),
    .cmd         (cmd),
    .src_waddr   (src_waddr),
    .src_raddr   (src_raddr),
    .fac_raddr_a (fac_raddr_a),
    .fac_raddr_b (fac_raddr_b),
    .fac_waddr   (fac_waddr)
  );

  chf_datapath #(
    .MAX_N     (MAX_N),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .src_waddr   (src_waddr),
    .src_raddr   (src_raddr),
    .fac_raddr_a (fac_raddr_a),
    .fac_raddr_b (fac_raddr_b),
    .fac_waddr   (fac_waddr),
    .in_data     (in_item.element_value),
    .stat        (stat),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire
